/* sv/pot_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the periodic / one-shot down timer
// no dependencies; imported by every module of the block
package pot_pkg;

	localparam int OP_W       = 3;
	localparam int UNIT_W     = 2;
	localparam int AMOUNT_W   = 32;
	localparam int CLK_HZ_W   = 27;
	localparam int CPU_W      = 7;
	localparam int ELAPSED_W  = 32;
	localparam int ERR_W      = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 27;
	localparam int IN_USER_W  = OP_W + UNIT_W;
	localparam int OUT_DATA_W = 40;

	// divisor width covers one million, the largest divisor ever used
	localparam int DVS_W      = 20;
	// whole seconds of a 32-bit microsecond amount
	localparam int US_QW      = 13;
	localparam int PR_HZ_W    = US_QW + CLK_HZ_W;
	localparam int PR_CPU_W   = CPU_W + DVS_W;
	localparam int US_PER_S   = 1000000;

	// amount / 1e6 as (amount >> 6) / 15625 by reciprocal multiply,
	// exact for every 26-bit shifted amount
	localparam int US_SH    = 6;
	localparam int RCP_X_W  = AMOUNT_W - US_SH;
	localparam int RCP_M_W  = 27;
	localparam int RCP_SH   = 40;
	localparam int RCP_PR_W = RCP_X_W + RCP_M_W;
	localparam logic [RCP_M_W-1:0] RCP_M = RCP_M_W'(70368745);

	localparam logic [CLK_HZ_W-1:0] CLK_HZ_RESET = CLK_HZ_W'(48000000);
	localparam logic [CPU_W-1:0]    CPU_RESET    = CPU_W'(48);

	localparam logic [OP_W-1:0] OP_TICK  = 3'd0;
	localparam logic [OP_W-1:0] OP_START = 3'd1;
	localparam logic [OP_W-1:0] OP_STOP  = 3'd2;
	localparam logic [OP_W-1:0] OP_CLEAR = 3'd3;
	localparam logic [OP_W-1:0] OP_READ  = 3'd4;

	localparam logic [UNIT_W-1:0] UNIT_HZ  = 2'd0;
	localparam logic [UNIT_W-1:0] UNIT_US  = 2'd1;
	localparam logic [UNIT_W-1:0] UNIT_CLK = 2'd2;
	localparam logic [UNIT_W-1:0] UNIT_BAD = 2'd3;

	localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
	localparam logic [ERR_W-1:0] ERR_PARAM = 2'd1;
	localparam logic [ERR_W-1:0] ERR_UNIT  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_CLOCK_HZ   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CPU        = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_SHOT   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IRQ_ENABLE = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL,
		ST_SUM
	} state_t;

	typedef enum logic [1:0] {
		JOB_HZ,
		JOB_US,
		JOB_RD
	} job_t;

	typedef enum logic [1:0] {
		SRC_HZ,
		SRC_US,
		SRC_RD
	} div_src_t;

	typedef enum logic [1:0] {
		FIN_NONE,
		FIN_HZ,
		FIN_US,
		FIN_RD
	} fin_t;

	typedef struct packed {
		logic     apply;
		logic     div_load;
		div_src_t div_src;
		logic     split_en;
		logic     mul_en;
		fin_t     fin;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic hz_bad;
		logic cpu_zero;
	} sts_t;

	// first field in the highest bits
	typedef struct packed {
		logic                 running;
		logic [ERR_W-1:0]     error_code;
		logic [ELAPSED_W-1:0] elapsed_us;
		logic                 timeout_irq;
	} res_t;

endpackage

/* sv/pot_ctrl.sv */
`timescale 1ns / 1ps
// controller for the down timer: accepts items and sequences the shared divider
// depends on pot_pkg
module pot_ctrl import pot_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [OP_W-1:0]   operation,
	input  logic [UNIT_W-1:0] unit,
	input  sts_t            sts,
	input  logic            obuf_full,
	output cmd_t            cmd,
	output logic            push
);

	state_t state_q, state_d;
	job_t   job_q;
	logic   accept;
	logic   is_hz, is_us, is_rd, long_op;
	job_t   job_d;

	assign s_tready = (state_q == ST_IDLE) && !obuf_full;
	assign accept   = s_tvalid && s_tready;

	// items that leave idle for the divide sequence
	always_comb begin
		is_hz   = (operation == OP_START) && (unit == UNIT_HZ) && !sts.hz_bad;
		is_us   = (operation == OP_START) && (unit == UNIT_US);
		is_rd   = (operation == OP_READ) && !sts.cpu_zero;
		long_op = is_hz || is_us || is_rd;
		if (is_hz) begin
			job_d = JOB_HZ;
		end else if (is_us) begin
			job_d = JOB_US;
		end else begin
			job_d = JOB_RD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			job_q   <= JOB_HZ;
		end else begin
			state_q <= state_d;
			if (accept && long_op) begin
				job_q <= job_d;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && long_op) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (sts.div_done) begin
					state_d = (job_q == JOB_US) ? ST_MUL : ST_IDLE;
				end
			end
			ST_MUL: state_d = ST_SUM;
			ST_SUM: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.apply    = 1'b0;
		cmd.div_load = 1'b0;
		cmd.div_src  = SRC_HZ;
		cmd.split_en = 1'b0;
		cmd.mul_en   = 1'b0;
		cmd.fin      = FIN_NONE;
		push         = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (long_op) begin
						cmd.div_load = 1'b1;
						if (is_hz) begin
							cmd.div_src = SRC_HZ;
						end else if (is_us) begin
							cmd.div_src = SRC_US;
						end else begin
							cmd.div_src = SRC_RD;
						end
					end else begin
						cmd.apply = 1'b1;
						push      = 1'b1;
					end
				end
			end
			ST_DIV: begin
				if (sts.div_done) begin
					if (job_q == JOB_HZ) begin
						cmd.fin = FIN_HZ;
						push    = 1'b1;
					end else if (job_q == JOB_RD) begin
						cmd.fin = FIN_RD;
						push    = 1'b1;
					end else begin
						cmd.split_en = 1'b1;
					end
				end
			end
			ST_MUL: cmd.mul_en = 1'b1;
			ST_SUM: begin
				cmd.fin = FIN_US;
				push    = 1'b1;
			end
			default: ;
		endcase
	end

endmodule

/* sv/pot_dp.sv */
`timescale 1ns / 1ps
// datapath for the down timer: config registers, counter state, shared
// radix-2 divider and the microsecond products; depends on pot_pkg
module pot_dp import pot_pkg::*; #(
	parameter int COUNTER_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [OP_W-1:0]       operation,
	input  logic [UNIT_W-1:0]     unit,
	input  logic [AMOUNT_W-1:0]   amount,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	output res_t                  res
);

	localparam int CW    = COUNTER_WIDTH;
	localparam int DW    = (CW > AMOUNT_W) ? CW : AMOUNT_W;
	localparam int DCW   = $clog2(DW + 1);
	localparam int SUM_W = PR_HZ_W + 1;
	localparam int LW    = (CW > SUM_W) ? CW : SUM_W;
	localparam logic [DW-1:0] SAT_LIM = DW'(33'h0_FFFF_FFFF);

	logic [CLK_HZ_W-1:0] clock_hz_q;
	logic [CPU_W-1:0]    cpu_q;
	logic                one_shot_q;
	logic                irq_en_q;

	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] load_q, load_d;
	logic          en_q, en_d;
	logic          to_q, to_d;

	logic [DW-1:0]    dvd_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DCW-1:0]   div_cnt_q;
	logic [DVS_W:0]   rem_sh, rem_sub;

	logic [RCP_PR_W-1:0] rcp_q;
	logic [US_QW-1:0]    us_quo;
	logic [AMOUNT_W-1:0] us_qm, us_rem;

	logic [PR_HZ_W-1:0]  prod_hz_q;
	logic [PR_CPU_W-1:0] prod_cpu_q;

	logic [CW-1:0] clk_load, hz_load, us_load;
	logic [DW-1:0] amount_m1, quo_m1;
	logic [LW-1:0] us_sum;
	logic [ELAPSED_W-1:0] rd_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_hz_q <= CLK_HZ_RESET;
			cpu_q      <= CPU_RESET;
			one_shot_q <= 1'b0;
			irq_en_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CLOCK_HZ:   clock_hz_q <= cfg_data[CLK_HZ_W-1:0];
				REG_CPU:        cpu_q      <= cfg_data[CPU_W-1:0];
				REG_ONE_SHOT:   one_shot_q <= cfg_data[0];
				REG_IRQ_ENABLE: irq_en_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign sts.hz_bad   = (amount == '0) || (amount > AMOUNT_W'(US_PER_S));
	assign sts.cpu_zero = (cpu_q == '0);
	assign sts.div_done = (div_cnt_q == '0);

	// restoring divider, one quotient bit per cycle
	assign rem_sh  = {rem_q, dvd_q[DW-1]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	// microsecond amount split into whole seconds and leftover microseconds
	assign us_quo = rcp_q[RCP_SH +: US_QW];
	assign us_qm  = AMOUNT_W'(us_quo) * AMOUNT_W'(US_PER_S);
	assign us_rem = dvd_q[AMOUNT_W-1:0] - us_qm;

	always_ff @(posedge clk) begin
		if (cmd.div_load && (cmd.div_src == SRC_US)) begin
			rcp_q <= amount[AMOUNT_W-1:US_SH] * RCP_M;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.div_load && (cmd.div_src != SRC_US)) begin
			div_cnt_q <= DCW'(DW);
		end else if (div_cnt_q != '0) begin
			div_cnt_q <= div_cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			rem_q <= '0;
			case (cmd.div_src)
				SRC_HZ: begin
					dvd_q <= DW'(clock_hz_q);
					dvs_q <= amount[DVS_W-1:0];
				end
				SRC_US: begin
					dvd_q <= DW'(amount);
				end
				default: begin
					dvd_q <= DW'(load_q - count_q);
					dvs_q <= DVS_W'(cpu_q);
				end
			endcase
		end else if (cmd.split_en) begin
			dvd_q <= DW'(us_quo);
			rem_q <= us_rem[DVS_W-1:0];
		end else if (div_cnt_q != '0) begin
			if (!rem_sub[DVS_W]) begin
				rem_q <= rem_sub[DVS_W-1:0];
				dvd_q <= {dvd_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[DVS_W-1:0];
				dvd_q <= {dvd_q[DW-2:0], 1'b0};
			end
		end
	end

	// whole seconds times clock rate, leftover microseconds times clocks per us
	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_hz_q  <= dvd_q[US_QW-1:0] * clock_hz_q;
			prod_cpu_q <= cpu_q * rem_q;
		end
	end

	assign amount_m1 = DW'(amount) - DW'(1);
	assign clk_load  = amount_m1[CW-1:0];
	assign quo_m1    = dvd_q - DW'(1);
	assign hz_load   = quo_m1[CW-1:0];
	assign us_sum    = LW'(prod_hz_q) + LW'(prod_cpu_q) - LW'(1);
	assign us_load   = us_sum[CW-1:0];
	assign rd_sat    = (dvd_q > SAT_LIM) ? '1 : dvd_q[ELAPSED_W-1:0];

	always_comb begin
		count_d        = count_q;
		load_d         = load_q;
		en_d           = en_q;
		to_d           = to_q;
		res.error_code = ERR_OK;
		res.elapsed_us = '0;
		if (cmd.apply) begin
			case (operation)
				OP_TICK: begin
					if (en_q) begin
						if (count_q == '0) begin
							to_d = 1'b1;
							if (one_shot_q) begin
								en_d = 1'b0;
							end else begin
								count_d = load_q;
							end
						end else begin
							count_d = count_q - 1'b1;
						end
					end
				end
				OP_START: begin
					// hertz starts only land here when rejected; microsecond starts never do
					case (unit)
						UNIT_CLK: begin
							load_d  = clk_load;
							count_d = clk_load;
							en_d    = 1'b1;
						end
						UNIT_BAD: res.error_code = ERR_UNIT;
						default:  res.error_code = ERR_PARAM;
					endcase
				end
				OP_STOP:  en_d = 1'b0;
				OP_CLEAR: to_d = 1'b0;
				OP_READ:  res.elapsed_us = '1;
				default: ;
			endcase
		end
		case (cmd.fin)
			FIN_HZ: begin
				load_d  = hz_load;
				count_d = hz_load;
				en_d    = 1'b1;
			end
			FIN_US: begin
				load_d  = us_load;
				count_d = us_load;
				en_d    = 1'b1;
			end
			FIN_RD:  res.elapsed_us = rd_sat;
			default: ;
		endcase
		res.timeout_irq = to_d & irq_en_q;
		res.running     = en_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			load_q  <= '0;
			en_q    <= 1'b0;
			to_q    <= 1'b0;
		end else begin
			count_q <= count_d;
			load_q  <= load_d;
			en_q    <= en_d;
			to_q    <= to_d;
		end
	end

endmodule

/* sv/pot_obuf.sv */
`timescale 1ns / 1ps
// two-entry result buffer between the timer core and the master stream side
// depends on pot_pkg
module pot_obuf import pot_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t push_data,
	output logic full,
	output logic m_tvalid,
	input  logic m_tready,
	output res_t m_res
);

	res_t       mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign m_tvalid = (cnt_q != 2'd0);
	assign full     = (cnt_q == 2'd2);
	assign pop      = m_tvalid && m_tready;
	assign m_res    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

/* sv/periodic_oneshot_down_timer.sv */
`timescale 1ns / 1ps
// top level of the periodic / one-shot down timer
// depends on pot_pkg, pot_ctrl, pot_dp, pot_obuf
//
// Usage: each transaction on the slave stream is one command (tuser holds
// operation and unit, tdata the amount); each one yields exactly one status
// transaction on the master stream. The config port writes clock_hz,
// clocks_per_us, one_shot and irq_enable; write it only while the block is idle.
// Tick, stop, clear, clock-unit start, rejected starts and reads with zero
// clocks per microsecond push their status in the cycle of acceptance: a tick
// can be taken every cycle while the result buffer has room. Hertz starts and
// elapsed reads run through the bit-serial divider over DW dividend bits,
// DW = max(COUNTER_WIDTH, 32). Microsecond starts split the amount by a
// reciprocal multiply, then pass the DIV, MUL and SUM states. Both push the
// status on the way back to idle, and s_tready stays low meanwhile.
// Results land in a two-entry buffer, so a new command is taken while one
// result still waits; with both entries full s_tready drops until the
// receiver takes one. Reset restores the config defaults (48 MHz, clocks_per_us
// of 48, periodic, interrupt masked), clears the counter, load, enable and
// timeout flag, and empties the result buffer.
module periodic_oneshot_down_timer import pot_pkg::*; #(
	parameter int COUNTER_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [AMOUNT_W-1:0]   s_tdata,  // amount
	input  logic [IN_USER_W-1:0]  s_tuser,  // operation, unit
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata   // timeout_irq, elapsed_us, error_code, running
);

	cmd_t cmd;
	sts_t sts;
	res_t res, m_res;
	logic push, obuf_full;

	pot_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.operation (s_tuser[OP_W-1:0]),
		.unit      (s_tuser[IN_USER_W-1:OP_W]),
		.sts       (sts),
		.obuf_full (obuf_full),
		.cmd       (cmd),
		.push      (push)
	);

	pot_dp #(
		.COUNTER_WIDTH (COUNTER_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.operation (s_tuser[OP_W-1:0]),
		.unit      (s_tuser[IN_USER_W-1:OP_W]),
		.amount    (s_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.res       (res)
	);

	pot_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (res),
		.full      (obuf_full),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_res     (m_res)
	);

	assign m_tdata = OUT_DATA_W'(m_res);

endmodule
